[hw/rtl/fbmf_pkg.sv]
// fbmf_pkg: shared constants, register indexes, reset values and sequencer states
// for the block-mean fir filter; no dependencies
`default_nettype none

package fbmf_pkg;

  localparam int SAMPLE_BITS      = 12;
  localparam int TAP_COUNT        = 10;
  localparam int COEF_REGS        = TAP_COUNT / 2;
  localparam int COEF_BITS        = 15;
  localparam int FRAC_BITS        = 15;
  localparam int MEAN_BITS        = 16;
  localparam int MEAN_FRAC        = 4;
  localparam int BLOCK_LENGTH_DEF = 10;
  localparam int CFG_IDX_BITS     = 3;

  typedef logic [COEF_BITS-1:0] coef_t;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_OUTER  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_SECOND = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_THIRD  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_FOURTH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_CENTER = 3'd4;

  localparam coef_t COEF_RESET [COEF_REGS] = '{
    15'd525, 15'd1237, 15'd3047, 15'd5112, 15'd6463
  };

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MAC    = 9'b000000010,
    ST_ACC    = 9'b000000100,
    ST_ROUND  = 9'b000001000,
    ST_MEAN_A = 9'b000010000,
    ST_MEAN_B = 9'b000100000,
    ST_MEAN_C = 9'b001000000,
    ST_MEAN_D = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/fir_block_mean_filter_top.sv]
// fir_block_mean_filter_top: symmetric 10-tap low-pass fir with block means,
// built around one shared multiplier; depends on fbmf_pkg
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | in        | in_valid/in_stall  | in_sample
//  out     | out       | out_valid/out_stall| out_filtered_sample, out_block_done,
//          |           |                    | out_raw_mean, out_filtered_mean
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one sample runs from its transfer to the next possible transfer through five
// multiplies on the shared multiplier (one per mirrored coefficient pair),
// one drain add, one round/saturate, one output load and the idle state that
// takes the next transfer; a sample that closes a block takes 4 more steps, two
// reciprocal multiplies on the same multiplier plus two correction steps for
// the two means
// reset clears the delay line, the block count, both sums, the coefficients
// (to their defaults) and the output valid
// a finished result sits in the output register, so a stalled consumer holds
// only the output load step; the input is stalled whenever the sequencer is busy
`default_nettype none

module fir_block_mean_filter_top #(
  parameter int BLOCK_LENGTH = fbmf_pkg::BLOCK_LENGTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // sample input
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic [fbmf_pkg::SAMPLE_BITS-1:0]   in_sample,
  // results
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic [fbmf_pkg::SAMPLE_BITS-1:0]   out_filtered_sample,
  output      logic                               out_block_done,
  output      logic [fbmf_pkg::MEAN_BITS-1:0]     out_raw_mean,
  output      logic [fbmf_pkg::MEAN_BITS-1:0]     out_filtered_mean,
  // coefficient writes
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [fbmf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [fbmf_pkg::COEF_BITS-1:0]     cfg_data
);

  localparam int SB      = fbmf_pkg::SAMPLE_BITS;
  localparam int NTAP    = fbmf_pkg::TAP_COUNT;
  localparam int NCOEF   = fbmf_pkg::COEF_REGS;
  localparam int CB      = fbmf_pkg::COEF_BITS;
  localparam int FB      = fbmf_pkg::FRAC_BITS;
  localparam int MB      = fbmf_pkg::MEAN_BITS;
  localparam int MF      = fbmf_pkg::MEAN_FRAC;
  // pair sum of two mirrored taps
  localparam int PSUM_W  = SB + 1;
  // five pair products never overflow this
  localparam int ACC_W   = PSUM_W + CB + $clog2(NCOEF + 1);
  localparam int IDX_W   = $clog2(NCOEF);
  localparam int CNT_W   = (BLOCK_LENGTH > 1) ? $clog2(BLOCK_LENGTH) : 1;
  // block sums and the scaled mean dividend
  localparam int SUM_W   = $clog2(BLOCK_LENGTH * ((1 << SB) - 1) + 1);
  localparam int D_W     = SUM_W + MF;
  localparam int MUL_A_W = (D_W > PSUM_W) ? D_W : PSUM_W;
  localparam int MUL_B_W = (D_W + 1 > CB) ? D_W + 1 : CB;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int QBL_W   = D_W + $clog2(BLOCK_LENGTH + 1);
  // floor(2^D_W / BLOCK_LENGTH); the quotient estimate is at most one low
  localparam longint unsigned RECIP_VAL = (64'd1 << D_W) / BLOCK_LENGTH;
  localparam logic [MUL_B_W-1:0] MEAN_RECIP = MUL_B_W'(RECIP_VAL);
  localparam logic [D_W-1:0]     HALF_BL    = D_W'(BLOCK_LENGTH / 2);

  fbmf_pkg::state_t state_r, state_nxt;

  fbmf_pkg::coef_t     coef_r [NCOEF];
  logic [SB-1:0]       delay_r [NTAP-1];
  logic [PSUM_W-1:0]   psum_r [NCOEF];
  logic [PSUM_W-1:0]   psum_nxt [NCOEF];
  logic [SB-1:0]       x_r;
  logic [IDX_W-1:0]    idx_r;
  logic [PROD_W-1:0]   prod_r;
  logic [ACC_W-1:0]    acc_r;
  logic [SB-1:0]       y_r;
  logic [CNT_W-1:0]    count_r;
  logic [SUM_W-1:0]    raw_sum_r;
  logic [SUM_W-1:0]    filt_sum_r;
  logic                block_end_r;
  logic [D_W-1:0]      q_r;
  logic [MB-1:0]       raw_mean_r;
  logic [MB-1:0]       filt_mean_r;

  logic                out_valid_r;
  logic [SB-1:0]       out_filt_r;
  logic                out_done_r;
  logic [MB-1:0]       out_raw_mean_r;
  logic [MB-1:0]       out_filt_mean_r;

  logic                in_xfer;
  logic                out_load;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [ACC_W-1:0]    acc_rnd;
  logic [ACC_W-FB-1:0] y_full;
  logic [SB-1:0]       y_sat;
  logic [D_W-1:0]      d_raw;
  logic [D_W-1:0]      d_filt;
  logic [D_W-1:0]      d_fix;
  logic [QBL_W-1:0]    q_bl;
  logic [QBL_W-1:0]    rem;
  logic [D_W:0]        q_fix;
  logic [MB-1:0]       mean_sat;

  assign in_stall  = (state_r != fbmf_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  // output register free, or being emptied this cycle
  assign out_load  = (state_r == fbmf_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_filt_r;
  assign out_block_done      = out_done_r;
  assign out_raw_mean        = out_raw_mean_r;
  assign out_filtered_mean   = out_filt_mean_r;

  // mirrored tap pairs: tap k plus tap 9-k, tap 0 is the arriving sample
  always_comb begin
    for (int k = 0; k < NCOEF; k++) begin
      if (k == 0) begin
        psum_nxt[k] = PSUM_W'(in_sample) + PSUM_W'(delay_r[NTAP-2]);
      end else begin
        psum_nxt[k] = PSUM_W'(delay_r[k-1]) + PSUM_W'(delay_r[NTAP-2-k]);
      end
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      fbmf_pkg::ST_MEAN_A: begin
        mul_a = MUL_A_W'(d_raw);
        mul_b = MEAN_RECIP;
      end
      fbmf_pkg::ST_MEAN_B: begin
        mul_a = MUL_A_W'(d_filt);
        mul_b = MEAN_RECIP;
      end
      default: begin
        mul_a = MUL_A_W'(psum_r[0]);
        mul_b = MUL_B_W'(coef_r[idx_r]);
      end
    endcase
  end

  // round half up, saturate to the sample range
  assign acc_rnd = acc_r + ACC_W'(1 << (FB - 1));
  assign y_full  = acc_rnd[ACC_W-1:FB];
  assign y_sat   = (y_full > (ACC_W-FB)'((1 << SB) - 1)) ? '1 : SB'(y_full);

  // mean dividends: 16 * sum + BLOCK_LENGTH / 2
  assign d_raw  = {raw_sum_r, MF'(0)} + HALF_BL;
  assign d_filt = {filt_sum_r, MF'(0)} + HALF_BL;

  // quotient correction: remainder below twice the divisor, one compare
  assign d_fix    = (state_r == fbmf_pkg::ST_MEAN_C) ? d_raw : d_filt;
  assign q_bl     = QBL_W'(q_r) * QBL_W'(BLOCK_LENGTH);
  assign rem      = QBL_W'(d_fix) - q_bl;
  assign q_fix    = (D_W+1)'(q_r) + (D_W+1)'(rem >= QBL_W'(BLOCK_LENGTH));
  assign mean_sat = (q_fix > (D_W+1)'((1 << MB) - 1)) ? '1 : MB'(q_fix);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbmf_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = fbmf_pkg::ST_MAC;
      end
      fbmf_pkg::ST_MAC: begin
        if (idx_r == IDX_W'(NCOEF - 1)) state_nxt = fbmf_pkg::ST_ACC;
      end
      fbmf_pkg::ST_ACC:    state_nxt = fbmf_pkg::ST_ROUND;
      fbmf_pkg::ST_ROUND: begin
        if (count_r == CNT_W'(BLOCK_LENGTH - 1)) begin
          state_nxt = fbmf_pkg::ST_MEAN_A;
        end else begin
          state_nxt = fbmf_pkg::ST_EMIT;
        end
      end
      fbmf_pkg::ST_MEAN_A: state_nxt = fbmf_pkg::ST_MEAN_B;
      fbmf_pkg::ST_MEAN_B: state_nxt = fbmf_pkg::ST_MEAN_C;
      fbmf_pkg::ST_MEAN_C: state_nxt = fbmf_pkg::ST_MEAN_D;
      fbmf_pkg::ST_MEAN_D: state_nxt = fbmf_pkg::ST_EMIT;
      fbmf_pkg::ST_EMIT: begin
        if (out_load) state_nxt = fbmf_pkg::ST_IDLE;
      end
      default:             state_nxt = fbmf_pkg::ST_IDLE;
    endcase
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbmf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      raw_sum_r   <= '0;
      filt_sum_r  <= '0;
      for (int i = 0; i < NTAP - 1; i++) delay_r[i] <= '0;
      for (int i = 0; i < NCOEF; i++) coef_r[i] <= fbmf_pkg::COEF_RESET[i];
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fbmf_pkg::CFG_COEF_OUTER:  coef_r[0] <= cfg_data;
          fbmf_pkg::CFG_COEF_SECOND: coef_r[1] <= cfg_data;
          fbmf_pkg::CFG_COEF_THIRD:  coef_r[2] <= cfg_data;
          fbmf_pkg::CFG_COEF_FOURTH: coef_r[3] <= cfg_data;
          fbmf_pkg::CFG_COEF_CENTER: coef_r[4] <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == fbmf_pkg::ST_ROUND) begin
        // shift the delay line, fold the sample into the block
        delay_r[0] <= x_r;
        for (int i = 1; i < NTAP - 1; i++) delay_r[i] <= delay_r[i-1];
        raw_sum_r  <= raw_sum_r + SUM_W'(x_r);
        filt_sum_r <= filt_sum_r + SUM_W'(y_sat);
        if (count_r == CNT_W'(BLOCK_LENGTH - 1)) begin
          count_r <= '0;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end

      if (state_r == fbmf_pkg::ST_MEAN_D) begin
        raw_sum_r  <= '0;
        filt_sum_r <= '0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      fbmf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          x_r    <= in_sample;
          idx_r  <= '0;
          prod_r <= '0;
          acc_r  <= '0;
          for (int k = 0; k < NCOEF; k++) psum_r[k] <= psum_nxt[k];
        end
      end
      fbmf_pkg::ST_MAC: begin
        prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
        acc_r  <= acc_r + ACC_W'(prod_r);
        idx_r  <= idx_r + IDX_W'(1);
        for (int k = 0; k < NCOEF - 1; k++) psum_r[k] <= psum_r[k+1];
      end
      fbmf_pkg::ST_ACC: begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      fbmf_pkg::ST_ROUND: begin
        y_r         <= y_sat;
        block_end_r <= (count_r == CNT_W'(BLOCK_LENGTH - 1));
      end
      fbmf_pkg::ST_MEAN_A: begin
        prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      fbmf_pkg::ST_MEAN_B: begin
        q_r    <= prod_r[D_W +: D_W];
        prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      fbmf_pkg::ST_MEAN_C: begin
        raw_mean_r <= mean_sat;
        q_r        <= prod_r[D_W +: D_W];
      end
      fbmf_pkg::ST_MEAN_D: begin
        filt_mean_r <= mean_sat;
      end
      fbmf_pkg::ST_EMIT: begin
        if (out_load) begin
          out_filt_r      <= y_r;
          out_done_r      <= block_end_r;
          out_raw_mean_r  <= block_end_r ? raw_mean_r : '0;
          out_filt_mean_r <= block_end_r ? filt_mean_r : '0;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // a transfer always starts the multiply sequence
  a_xfer_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == fbmf_pkg::ST_MAC))
    else $error("sample transfer did not start the mac sequence");

  // block position never reaches the block length
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(BLOCK_LENGTH - 1))
    else $error("block count out of range");

  // means are zero on results that do not close a block
  a_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_done_r) |-> (out_raw_mean_r == '0 && out_filt_mean_r == '0))
    else $error("nonzero mean outside a block end");

  // an output load always leaves a valid result
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("output load lost");

  // block sums are clear whenever a new block starts
  a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fbmf_pkg::ST_MEAN_D) |=> (raw_sum_r == '0 && filt_sum_r == '0))
    else $error("block sums not cleared at block end");
`endif

endmodule

`default_nettype wire
